@@ rtl/cet_pkg.sv @@
// Shared types, constants and register indexes for the cell escape time unit.
// No dependencies; every other file imports this package.
package cet_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_PARTICLES = 65536;
    localparam int TOL_BITS      = 16;
    localparam int CELL_W        = 11;
    localparam int CDIV_STEPS    = CELL_W;
    localparam int TIME_W        = 32;
    localparam int TDIV_STEPS    = TIME_W;
    localparam int LO_W          = CELL_W + 32;
    localparam int DIFF_W        = LO_W + 2;
    localparam int DIST_W        = 34;
    localparam int TOLSC_W       = TOL_BITS + 32;
    localparam int TREM_W        = DIST_W + FRAC_BITS;
    localparam int TCMP_W        = 32 + TDIV_STEPS;
    localparam int NEAR_W        = DIFF_W + TOL_BITS;
    localparam int AXIS_LAT      = CDIV_STEPS + TDIV_STEPS + 7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam int REG_W = 3;
    localparam logic [REG_W-1:0] REG_CELL_SIZE_X  = 3'd0;
    localparam logic [REG_W-1:0] REG_CELL_SIZE_Y  = 3'd1;
    localparam logic [REG_W-1:0] REG_CELL_SIZE_Z  = 3'd2;
    localparam logic [REG_W-1:0] REG_CELLS_X      = 3'd3;
    localparam logic [REG_W-1:0] REG_CELLS_Y      = 3'd4;
    localparam logic [REG_W-1:0] REG_CELLS_Z      = 3'd5;
    localparam logic [REG_W-1:0] REG_FACE_TOL     = 3'd6;
    localparam logic [REG_W-1:0] REG_LIST_ENABLE  = 3'd7;

    typedef struct packed {
        logic [15:0]        particle_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } cet_in_t;

    typedef struct packed {
        logic [15:0]       result_index;
        logic [TIME_W-1:0] escape_time;
        logic              no_exit;
        logic              time_written;
    } cet_out_t;

    typedef struct packed {
        logic [31:0]         cell_size;
        logic [CELL_W-1:0]   cells;
        logic [TOL_BITS-1:0] tol;
    } cet_axis_cfg_t;

    typedef struct packed {
        cet_axis_cfg_t x;
        cet_axis_cfg_t y;
        cet_axis_cfg_t z;
        logic          enable;
    } cet_cfg_t;

endpackage

@@ rtl/cet_cfg.sv @@
// Configuration register file for the cell escape time unit.
// Depends on cet_pkg.
module cet_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [cet_pkg::REG_W-1:0] wr_index,
    input  logic [31:0]              wr_data,
    output cet_pkg::cet_cfg_t        cfg
);
    import cet_pkg::*;

    cet_cfg_t cfg_reg;
    cet_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_CELL_SIZE_X: cfg_next.x.cell_size = wr_data;
                REG_CELL_SIZE_Y: cfg_next.y.cell_size = wr_data;
                REG_CELL_SIZE_Z: cfg_next.z.cell_size = wr_data;
                REG_CELLS_X:     cfg_next.x.cells     = wr_data[CELL_W-1:0];
                REG_CELLS_Y:     cfg_next.y.cells     = wr_data[CELL_W-1:0];
                REG_CELLS_Z:     cfg_next.z.cells     = wr_data[CELL_W-1:0];
                REG_FACE_TOL:
                begin
                    cfg_next.x.tol = wr_data[TOL_BITS-1:0];
                    cfg_next.y.tol = wr_data[TOL_BITS-1:0];
                    cfg_next.z.tol = wr_data[TOL_BITS-1:0];
                end
                REG_LIST_ENABLE: cfg_next.enable      = wr_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x.cell_size <= 32'd65536;
            cfg_reg.y.cell_size <= 32'd65536;
            cfg_reg.z.cell_size <= 32'd65536;
            cfg_reg.x.cells     <= CELL_W'(1);
            cfg_reg.y.cells     <= CELL_W'(1);
            cfg_reg.z.cells     <= CELL_W'(1);
            cfg_reg.x.tol       <= '0;
            cfg_reg.y.tol       <= '0;
            cfg_reg.z.tol       <= '0;
            cfg_reg.enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/cet_axis.sv @@
// One axis of the escape time pipeline: cell divide, clamp, face test, time divide.
// Depends on cet_pkg; all stages advance together on en.
module cet_axis (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [31:0]         pos,
    input  logic signed [31:0]         vel,
    input  cet_pkg::cet_axis_cfg_t     cfg,
    output logic [cet_pkg::TIME_W-1:0] axis_time
);
    import cet_pkg::*;

    logic [31:0]       size_e;
    logic [CELL_W-1:0] nmax;

    // cell divide stages
    logic signed [31:0] cd_p_reg    [0:CDIV_STEPS];
    logic signed [31:0] cd_v_reg    [0:CDIV_STEPS];
    logic [30:0]        cd_rem_reg  [0:CDIV_STEPS];
    logic [CELL_W-1:0]  cd_q_reg    [0:CDIV_STEPS];
    logic               cd_neg_reg  [0:CDIV_STEPS];
    logic               cd_big_reg  [0:CDIV_STEPS];
    logic [30:0]        cd_rem_next [1:CDIV_STEPS];
    logic [CELL_W-1:0]  cd_q_next   [1:CDIV_STEPS];

    // clamp, face and select stages
    logic signed [31:0] b_p_reg, c_v_reg, d_v_reg;
    logic signed [31:0] b_v_reg;
    logic [LO_W-1:0]    b_lo_reg, b_lo_next;
    logic [TOLSC_W-1:0] b_tolsc_reg, c_tolsc_reg;
    logic [CELL_W-1:0]  b_n;
    logic signed [DIFF_W-1:0] c_dlo_reg, c_dhi_reg, d_dlo_reg, d_dhi_reg;
    logic [LO_W:0]      c_hi;
    logic [DIFF_W-1:0]  d_adlo, d_adhi;
    logic               d_on_face_reg, d_on_face_next;
    logic signed [DIFF_W-1:0] e_dist;

    // time divide stages
    logic [TREM_W-1:0]  td_rem_reg    [0:TDIV_STEPS];
    logic [TIME_W-1:0]  td_q_reg      [0:TDIV_STEPS];
    logic [31:0]        td_speed_reg  [0:TDIV_STEPS];
    logic               td_vzero_reg  [0:TDIV_STEPS];
    logic               td_np_reg     [0:TDIV_STEPS];
    logic               td_ov_reg     [0:TDIV_STEPS];
    logic [TREM_W-1:0]  td_rem_next   [1:TDIV_STEPS];
    logic [TIME_W-1:0]  td_q_next     [1:TDIV_STEPS];
    logic [DIST_W-1:0]  e_dist_reg;
    logic [31:0]        e_speed_reg;
    logic               e_vzero_reg, e_np_reg;
    logic [TIME_W-1:0]  time_reg;

    assign size_e = (cfg.cell_size == '0) ? 32'd1 : cfg.cell_size;
    assign nmax   = (cfg.cells == '0) ? '0 : cfg.cells - CELL_W'(1);

    always_comb
    begin
        logic [LO_W-1:0] sh;
        for (int j = 1; j <= CDIV_STEPS; j++)
        begin
            sh = LO_W'(size_e) << (CDIV_STEPS - j);
            cd_rem_next[j] = cd_rem_reg[j-1];
            cd_q_next[j]   = cd_q_reg[j-1];
            if (LO_W'(cd_rem_reg[j-1]) >= sh)
            begin
                cd_rem_next[j] = 31'(LO_W'(cd_rem_reg[j-1]) - sh);
                cd_q_next[j][CDIV_STEPS-j] = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [CELL_W-1:0] q;
        q = cd_q_reg[CDIV_STEPS];
        if (cd_neg_reg[CDIV_STEPS])
            b_n = '0;
        else if (cd_big_reg[CDIV_STEPS] || q > nmax)
            b_n = nmax;
        else
            b_n = q;
        b_lo_next = LO_W'(b_n) * LO_W'(size_e);
    end

    assign c_hi = (LO_W+1)'(b_lo_reg) + (LO_W+1)'(size_e);

    assign d_adlo = c_dlo_reg[DIFF_W-1] ? DIFF_W'(-c_dlo_reg) : DIFF_W'(c_dlo_reg);
    assign d_adhi = c_dhi_reg[DIFF_W-1] ? DIFF_W'(-c_dhi_reg) : DIFF_W'(c_dhi_reg);

    always_comb
    begin
        d_on_face_next = 1'b0;
        if ({d_adlo, TOL_BITS'(0)} < NEAR_W'(c_tolsc_reg))
            d_on_face_next = c_v_reg < 0;
        else if ({d_adhi, TOL_BITS'(0)} < NEAR_W'(c_tolsc_reg))
            d_on_face_next = c_v_reg > 0;
    end

    always_comb
    begin
        if (d_on_face_reg)
            e_dist = $signed(DIFF_W'(size_e));
        else if (d_v_reg > 0)
            e_dist = -d_dhi_reg;
        else
            e_dist = d_dlo_reg;
    end

    always_comb
    begin
        logic [TCMP_W-1:0] sh;
        for (int j = 1; j <= TDIV_STEPS; j++)
        begin
            sh = TCMP_W'(td_speed_reg[j-1]) << (TDIV_STEPS - j);
            td_rem_next[j] = td_rem_reg[j-1];
            td_q_next[j]   = td_q_reg[j-1];
            if (TCMP_W'(td_rem_reg[j-1]) >= sh)
            begin
                td_rem_next[j] = TREM_W'(TCMP_W'(td_rem_reg[j-1]) - sh);
                td_q_next[j][TDIV_STEPS-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_p_reg[0]   <= pos;
            cd_v_reg[0]   <= vel;
            cd_rem_reg[0] <= pos[30:0];
            cd_q_reg[0]   <= '0;
            cd_neg_reg[0] <= pos[31];
            cd_big_reg[0] <= !pos[31] && (LO_W'(pos[30:0]) >= (LO_W'(size_e) << CDIV_STEPS));
            for (int j = 1; j <= CDIV_STEPS; j++)
            begin
                cd_p_reg[j]   <= cd_p_reg[j-1];
                cd_v_reg[j]   <= cd_v_reg[j-1];
                cd_rem_reg[j] <= cd_rem_next[j];
                cd_q_reg[j]   <= cd_q_next[j];
                cd_neg_reg[j] <= cd_neg_reg[j-1];
                cd_big_reg[j] <= cd_big_reg[j-1];
            end

            b_p_reg     <= cd_p_reg[CDIV_STEPS];
            b_v_reg     <= cd_v_reg[CDIV_STEPS];
            b_lo_reg    <= b_lo_next;
            b_tolsc_reg <= TOLSC_W'(cfg.tol) * TOLSC_W'(size_e);

            c_v_reg     <= b_v_reg;
            c_tolsc_reg <= b_tolsc_reg;
            c_dlo_reg   <= DIFF_W'(b_p_reg) - $signed(DIFF_W'(b_lo_reg));
            c_dhi_reg   <= DIFF_W'(b_p_reg) - $signed(DIFF_W'(c_hi));

            d_v_reg       <= c_v_reg;
            d_dlo_reg     <= c_dlo_reg;
            d_dhi_reg     <= c_dhi_reg;
            d_on_face_reg <= d_on_face_next;

            e_dist_reg  <= e_dist[DIST_W-1:0];
            e_np_reg    <= e_dist <= 0;
            e_vzero_reg <= d_v_reg == 0;
            e_speed_reg <= d_v_reg[31] ? 32'(-d_v_reg) : 32'(d_v_reg);

            td_rem_reg[0]   <= {e_dist_reg, FRAC_BITS'(0)};
            td_q_reg[0]     <= '0;
            td_speed_reg[0] <= e_speed_reg;
            td_vzero_reg[0] <= e_vzero_reg;
            td_np_reg[0]    <= e_np_reg;
            td_ov_reg[0]    <= TCMP_W'({e_dist_reg, FRAC_BITS'(0)})
                               >= (TCMP_W'(e_speed_reg) << TDIV_STEPS);
            for (int j = 1; j <= TDIV_STEPS; j++)
            begin
                td_rem_reg[j]   <= td_rem_next[j];
                td_q_reg[j]     <= td_q_next[j];
                td_speed_reg[j] <= td_speed_reg[j-1];
                td_vzero_reg[j] <= td_vzero_reg[j-1];
                td_np_reg[j]    <= td_np_reg[j-1];
                td_ov_reg[j]    <= td_ov_reg[j-1];
            end

            if (td_vzero_reg[TDIV_STEPS])
                time_reg <= TIME_MAX;
            else if (td_np_reg[TDIV_STEPS])
                time_reg <= '0;
            else if (td_ov_reg[TDIV_STEPS])
                time_reg <= TIME_MAX;
            else
                time_reg <= td_q_reg[TDIV_STEPS];
        end
    end

    assign axis_time = time_reg;

endmodule

@@ rtl/cell_escape_time_unit.sv @@
// Top level of the cell escape time unit: config registers, three axis
// pipelines, a side pipeline for index and flags, and the output register.
// Depends on cet_pkg, cet_cfg and cet_axis.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one particle per beat:
//   index, Q16.16 position and velocity. Output channel out_valid/out_ready/
//   out_item returns one result per beat, in input order.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes one register
//   per beat; cfg_ready is always high. Write only while the pipeline is empty.
//   Throughput: one particle per cycle unless the receiver stalls; the cell
//   divide takes one quotient bit per stage (11 stages) and the time divide
//   one bit per stage (32 stages).
//   When the receiver stalls, the whole pipeline holds and in_ready drops in
//   the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and loads cell sizes of 1.0, one cell per
//   axis, zero tolerance and the cell list disabled; in that state every
//   result has time_written low.
module cell_escape_time_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cet_pkg::cet_in_t          in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cet_pkg::cet_out_t         out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cet_pkg::REG_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);
    import cet_pkg::*;

    cet_cfg_t          cfg;
    logic              adv;
    logic [TIME_W-1:0] t_x, t_y, t_z, t_xy, t_min;

    logic              sd_valid_reg [0:AXIS_LAT-1];
    logic [15:0]       sd_idx_reg   [0:AXIS_LAT-1];
    logic              sd_vzero_reg [0:AXIS_LAT-1];

    logic              out_valid_reg;
    cet_out_t          out_reg, out_next;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;

    cet_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cet_axis u_axis_x (
        .clk       (clk),
        .en        (adv),
        .pos       (in_item.pos_x),
        .vel       (in_item.vel_x),
        .cfg       (cfg.x),
        .axis_time (t_x)
    );

    cet_axis u_axis_y (
        .clk       (clk),
        .en        (adv),
        .pos       (in_item.pos_y),
        .vel       (in_item.vel_y),
        .cfg       (cfg.y),
        .axis_time (t_y)
    );

    cet_axis u_axis_z (
        .clk       (clk),
        .en        (adv),
        .pos       (in_item.pos_z),
        .vel       (in_item.vel_z),
        .cfg       (cfg.z),
        .axis_time (t_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_LAT; i++)
                sd_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sd_valid_reg[0] <= in_valid;
            for (int i = 1; i < AXIS_LAT; i++)
                sd_valid_reg[i] <= sd_valid_reg[i-1];
            out_valid_reg <= sd_valid_reg[AXIS_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_idx_reg[0]   <= in_item.particle_index;
            sd_vzero_reg[0] <= (in_item.vel_x == 0) && (in_item.vel_y == 0)
                               && (in_item.vel_z == 0);
            for (int i = 1; i < AXIS_LAT; i++)
            begin
                sd_idx_reg[i]   <= sd_idx_reg[i-1];
                sd_vzero_reg[i] <= sd_vzero_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    assign t_xy  = (t_y < t_x) ? t_y : t_x;
    assign t_min = (t_z < t_xy) ? t_z : t_xy;

    always_comb
    begin
        out_next.result_index = sd_idx_reg[AXIS_LAT-1];
        out_next.escape_time  = '0;
        out_next.no_exit      = 1'b0;
        out_next.time_written = 1'b0;
        if (cfg.enable && (32'(sd_idx_reg[AXIS_LAT-1]) < 32'(MAX_PARTICLES)))
        begin
            out_next.escape_time  = t_min;
            out_next.no_exit      = sd_vzero_reg[AXIS_LAT-1];
            out_next.time_written = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

@@ rtl/cet_checker.sv @@
// Port-level checks for the cell escape time unit, bound to the top level.
// Depends on cet_pkg and cell_escape_time_unit.
module cet_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input cet_pkg::cet_in_t          in_item,
    input logic                      out_valid,
    input logic                      out_ready,
    input cet_pkg::cet_out_t         out_item,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [cet_pkg::REG_W-1:0] cfg_index,
    input logic [31:0]               cfg_data
);
    import cet_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result beat changed while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_no_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.no_exit |->
            out_item.time_written && (out_item.escape_time == TIME_MAX))
        else $error("no_exit without maximum time");

    a_unwritten: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.time_written |->
            (out_item.escape_time == '0) && !out_item.no_exit)
        else $error("unwritten result carries data");

endmodule

bind cell_escape_time_unit cet_checker u_cet_checker (.*);

@@ tb/cell_escape_time_unit_tb.sv @@
// Self-checking testbench for cell_escape_time_unit: directed table, then random
// particles under several idling phases and configurations. Depends on cet_pkg.
module cell_escape_time_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cet_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    cet_in_t in_item;
    logic out_valid;
    logic out_ready;
    cet_out_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [REG_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    cell_escape_time_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [31:0] cfg_size [3];
    logic [10:0] cfg_cells [3];
    logic [15:0] cfg_tol;
    logic        cfg_en;

    cet_out_t escape_q[$];
    int err_count;
    int beats_in;
    int beats_out;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at result %0d: got %h want %h", what, beats_out, got, want);
        err_count++;
    endtask

    function automatic logic [31:0] quot_time(input longint unsigned span,
                                              input longint unsigned speed);
        longint unsigned ip;
        longint unsigned rm;
        longint unsigned q;
        ip = span / speed;
        rm = span % speed;
        if ((ip >> (32 - FRAC_BITS)) != 0)
            return TIME_MAX;
        q = (ip << FRAC_BITS) + ((rm << FRAC_BITS) / speed);
        if (q > 64'hFFFF_FFFF)
            return TIME_MAX;
        return q[31:0];
    endfunction

    function automatic logic [31:0] axis_escape(input logic signed [31:0] p32,
                                                input logic signed [31:0] v32, input int a);
        longint p;
        longint v;
        longint sz;
        longint nc;
        longint n;
        longint lo;
        longint hi;
        longint tsc;
        longint span;
        longint dl;
        longint dh;
        bit face;
        p = p32;
        v = v32;
        sz = (cfg_size[a] == 0) ? 1 : longint'(cfg_size[a]);
        nc = (cfg_cells[a] == 0) ? 1 : longint'(cfg_cells[a]);
        face = 0;
        if (v == 0)
            return TIME_MAX;
        n = p / sz;
        if (n < 0)
            n = 0;
        if (n > nc - 1)
            n = nc - 1;
        lo = n * sz;
        hi = lo + sz;
        tsc = longint'(cfg_tol) * sz;
        dl = (p - lo < 0) ? lo - p : p - lo;
        dh = (p - hi < 0) ? hi - p : p - hi;
        if (dl * 65536 < tsc)
        begin
            if (v < 0)
                face = 1;
        end
        else if (dh * 65536 < tsc)
        begin
            if (v > 0)
                face = 1;
        end
        if (face)
            span = sz;
        else if (v > 0)
            span = hi - p;
        else
            span = p - lo;
        if (span <= 0)
            return 0;
        return quot_time(span, (v < 0) ? -v : v);
    endfunction

    function automatic cet_out_t predict_escape(input cet_in_t it);
        cet_out_t r;
        logic [31:0] t;
        logic [31:0] best;
        r = '0;
        r.result_index = it.particle_index;
        if (!cfg_en)
            return r;
        best = axis_escape(it.pos_x, it.vel_x, 0);
        t = axis_escape(it.pos_y, it.vel_y, 1);
        if (t < best)
            best = t;
        t = axis_escape(it.pos_z, it.vel_z, 2);
        if (t < best)
            best = t;
        r.escape_time = best;
        r.no_exit = (it.vel_x == 0 && it.vel_y == 0 && it.vel_z == 0);
        r.time_written = 1'b1;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (escape_q.size() == 0)
                begin
                    $display("unexpected result beat, index %h", out_item.result_index);
                    err_count++;
                end
                else
                begin
                    cet_out_t w;
                    w = escape_q.pop_front();
                    if (out_item.result_index !== w.result_index)
                        report_mismatch("result_index", out_item.result_index, w.result_index);
                    if (out_item.escape_time !== w.escape_time)
                        report_mismatch("escape_time", out_item.escape_time, w.escape_time);
                    if (out_item.no_exit !== w.no_exit)
                        report_mismatch("no_exit", out_item.no_exit, w.no_exit);
                    if (out_item.time_written !== w.time_written)
                        report_mismatch("time_written", out_item.time_written,
                                        w.time_written);
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CELL_SIZE_X: cfg_size[0] = val;
            REG_CELL_SIZE_Y: cfg_size[1] = val;
            REG_CELL_SIZE_Z: cfg_size[2] = val;
            REG_CELLS_X: cfg_cells[0] = val[10:0];
            REG_CELLS_Y: cfg_cells[1] = val[10:0];
            REG_CELLS_Z: cfg_cells[2] = val[10:0];
            REG_FACE_TOL: cfg_tol = val[15:0];
            default: cfg_en = val[0];
        endcase
    endtask

    task automatic set_grid(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz, input logic [10:0] cx,
                            input logic [10:0] cy, input logic [10:0] cz,
                            input logic [15:0] tol, input logic en);
        write_reg(REG_CELL_SIZE_X, sx);
        write_reg(REG_CELL_SIZE_Y, sy);
        write_reg(REG_CELL_SIZE_Z, sz);
        write_reg(REG_CELLS_X, {21'd0, cx});
        write_reg(REG_CELLS_Y, {21'd0, cy});
        write_reg(REG_CELLS_Z, {21'd0, cz});
        write_reg(REG_FACE_TOL, {16'd0, tol});
        write_reg(REG_LIST_ENABLE, {31'd0, en});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_particle(input cet_in_t it, input bit has_want,
                                 input cet_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_in++;
        if (has_want)
            escape_q.push_back(want);
        else
            escape_q.push_back(predict_escape(it));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (escape_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return -$urandom_range(3);
            2: return 32'h8000_0000 ^ $urandom_range(1);
            3: return $urandom_range(32'h0004_0000);
            4: return -$urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic cet_in_t rand_particle(input int well_formed);
        cet_in_t it;
        int a;
        logic [31:0] p;
        it.particle_index = 16'($urandom);
        it.pos_x = rand_word();
        it.pos_y = rand_word();
        it.pos_z = rand_word();
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        if (well_formed)
        begin
            for (a = 0; a < 3; a++)
            begin
                p = $urandom_range(cfg_cells[a]) * cfg_size[a];
                if ($urandom_range(1))
                    p = p + $urandom_range(2 * 32'(cfg_tol)) - 32'(cfg_tol);
                else
                    p = p + $urandom_range(cfg_size[a]);
                case (a)
                    0: it.pos_x = p;
                    1: it.pos_y = p;
                    default: it.pos_z = p;
                endcase
            end
            if ($urandom_range(15) == 0)
                {it.vel_x, it.vel_y, it.vel_z} = '0;
        end
        return it;
    endfunction

    typedef struct {
        cet_in_t  item;
        bit       has_want;
        cet_out_t want;
    } stim_row_t;

    stim_row_t dir_rows[$];

    function automatic cet_in_t mk(input logic [15:0] i, input logic [31:0] px,
                                   input logic [31:0] py, input logic [31:0] pz,
                                   input logic [31:0] vx, input logic [31:0] vy,
                                   input logic [31:0] vz);
        cet_in_t it;
        it = {i, px, py, pz, vx, vy, vz};
        return it;
    endfunction

    function automatic cet_out_t res(input logic [15:0] i, input logic [31:0] t,
                                     input logic ne, input logic tw);
        cet_out_t r;
        r = {i, t, ne, tw};
        return r;
    endfunction

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        int k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
            send_particle(rand_particle($urandom_range(99) < 80), 0, '0);
        drain_pipe();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        beats_in = 0;
        beats_out = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        cfg_size[0] = 32'd65536;
        cfg_size[1] = 32'd65536;
        cfg_size[2] = 32'd65536;
        cfg_cells[0] = 11'd1;
        cfg_cells[1] = 11'd1;
        cfg_cells[2] = 11'd1;
        cfg_tol = '0;
        cfg_en = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: disabled, results carry only the index
        send_particle(mk(16'hFFFF, 32'h7FFF_FFFF, 0, 0, 1, 1, 1), 1,
                      res(16'hFFFF, 0, 0, 0));
        send_particle(mk(16'h0000, 0, 0, 0, 0, 0, 0), 1, res(16'h0000, 0, 0, 0));
        drain_pipe();

        set_grid(32'd65536, 32'd65536, 32'd65536, 11'd4, 11'd4, 11'd4, 16'd0, 1'b1);
        dir_rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0), 1, res(1, TIME_MAX, 1, 1)});
        dir_rows.push_back('{mk(2, 32'h8000, 0, 0, 32'h10000, 0, 0), 1,
                             res(2, 32'h8000, 0, 1)});
        dir_rows.push_back('{mk(3, 32'h8000, 0, 0, 32'hFFFF_0000, 0, 0), 1,
                             res(3, 32'h8000, 0, 1)});
        dir_rows.push_back('{mk(4, 32'h8000_0000, 0, 0, 32'h10000, 0, 0), 1,
                             res(4, 32'h8001_0000, 0, 1)});
        dir_rows.push_back('{mk(5, 32'h8000_0000, 0, 0, 32'hFFFF_0000, 0, 0), 1,
                             res(5, 0, 0, 1)});
        dir_rows.push_back('{mk(6, 32'h7FFF_FFFF, 0, 0, 32'h10000, 0, 0), 1,
                             res(6, 0, 0, 1)});
        dir_rows.push_back('{mk(7, 32'h8000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1), 0,
                             '0});
        dir_rows.push_back('{mk(8, 32'h8000, 32'h8000, 32'h8000, 1, 0, 0), 1,
                             res(8, 32'h8000_0000, 0, 1)});
        dir_rows.push_back('{mk(9, 0, 32'h3FFFF, 0, 0, 32'h7FFF_FFFF, 0), 0, '0});
        for (k = 0; k < dir_rows.size(); k++)
            send_particle(dir_rows[k].item, dir_rows[k].has_want, dir_rows[k].want);
        drain_pipe();

        // face tolerance, zero size and zero count on x, and the largest size on z
        set_grid(32'd0, 32'd65536, 32'hFFFF_FFFF, 11'd0, 11'd1024, 11'd1024,
                 16'hFFFF, 1'b1);
        dir_rows.delete();
        dir_rows.push_back('{mk(10, 32'h10000, 32'h10000, 0, 32'h1, 32'hFFFF_0000, 0), 0,
                             '0});
        dir_rows.push_back('{mk(11, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 0, 32'h10000, 2), 0,
                             '0});
        dir_rows.push_back('{mk(12, 32'h4000_0000, 32'h0400_0000, 32'h7FFF_FFFF,
                                32'hFFFF_FFFF, 32'h1, 32'h8000_0000), 0, '0});
        for (k = 0; k < dir_rows.size(); k++)
            send_particle(dir_rows[k].item, dir_rows[k].has_want, dir_rows[k].want);
        drain_pipe();

        set_grid(32'd65536, 32'd40000, 32'd3, 11'd8, 11'd3, 11'd1000, 16'd8192, 1'b1);
        run_random(300, 0, 0);
        set_grid(32'h0002_8000, 32'd1, 32'hFFFF_FFFF, 11'd1, 11'd2047, 11'd16,
                 16'hFFFF, 1'b1);
        run_random(300, 48, 0);
        set_grid(32'd100, 32'h0100_0000, 32'h0001_0000, 11'd1024, 11'd5, 11'd2,
                 16'd1, 1'b1);
        run_random(300, 0, 48);
        set_grid(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 11'd3, 11'd3, 11'd3,
                 16'h4000, 1'b0);
        run_random(100, 18, 18);
        set_grid(32'h0000_8000, 32'h0003_0000, 32'd777, 11'd16, 11'd7, 11'd300,
                 16'h2000, 1'b1);
        run_random(300, 18, 18);

        hold_off = 300;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (k = 0; k < 300; k++)
            send_particle(rand_particle(1), 0, '0);
        drain_pipe();

        $display("%0d particles sent, %0d results checked across eight register settings",
                 beats_in, beats_out);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
